// ===== hdl/jpp_pkg.sv =====
// Package for the joint position PID: widths, register codes, reset values
// and the structs passed between the pipeline stages.
// Depends on nothing; every other file of the block uses it.
package jpp_pkg;

  localparam int JOINT_COUNT_DEF = 4;

  localparam int JOINT_W     = 2;
  localparam int ANGLE_W     = 15;
  localparam int ERR_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int LIM_W       = 8;
  localparam int FINE_W      = 14;
  localparam int PWM_W       = 9;
  localparam int ACC_W       = 32;
  localparam int FRAC_BITS   = 20;
  localparam int DEADBAND_LSB = 20;

  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int DPROD_W = DIFF_W + GAIN_W + 1;
  localparam int SUM_W  = ACC_W + 2;
  localparam int VEL_W  = DPROD_W + 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN     = 4'd0,
    CFG_I_GAIN     = 4'd1,
    CFG_D_GAIN     = 4'd2,
    CFG_I_LIMIT    = 4'd3,
    CFG_FINE_ANGLE = 4'd4,
    CFG_VEL_LIMIT  = 4'd5,
    CFG_MIN_PWM    = 4'd6,
    CFG_MAX_PWM    = 4'd7
  } cfg_idx_t;

  localparam logic [GAIN_W-1:0] P_GAIN_RST     = 16'd256;
  localparam logic [GAIN_W-1:0] I_GAIN_RST     = 16'd0;
  localparam logic [GAIN_W-1:0] D_GAIN_RST     = 16'd0;
  localparam logic [LIM_W-1:0]  I_LIMIT_RST    = 8'd255;
  localparam logic [FINE_W-1:0] FINE_ANGLE_RST = 14'd410;
  localparam logic [LIM_W-1:0]  VEL_LIMIT_RST  = 8'd255;
  localparam logic [LIM_W-1:0]  MIN_PWM_RST    = 8'd0;
  localparam logic [LIM_W-1:0]  MAX_PWM_RST    = 8'd255;

  typedef struct packed {
    logic [GAIN_W-1:0] p_gain;
    logic [GAIN_W-1:0] i_gain;
    logic [GAIN_W-1:0] d_gain;
    logic [LIM_W-1:0]  i_limit;
    logic [FINE_W-1:0] fine_angle;
    logic [LIM_W-1:0]  vel_limit;
    logic [LIM_W-1:0]  min_pwm;
    logic [LIM_W-1:0]  max_pwm;
  } cfg_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint;
    logic                      joint_ok;
    logic                      moving;
    logic                      fine;
    logic signed [PROD_W-1:0]  p;
    logic signed [PROD_W-1:0]  ei;
    logic signed [DPROD_W-1:0] d;
  } term_t;

endpackage

// ===== hdl/jpp_cfg_regs.sv =====
// Configuration register file of the joint position PID.
// Depends on jpp_pkg for register codes, reset values and cfg_t.
module jpp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [jpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output jpp_pkg::cfg_t                    cfg
);

  jpp_pkg::cfg_t cfg_r;
  jpp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (jpp_pkg::cfg_idx_t'(cfg_index))
        jpp_pkg::CFG_P_GAIN:     cfg_nxt.p_gain     = cfg_data;
        jpp_pkg::CFG_I_GAIN:     cfg_nxt.i_gain     = cfg_data;
        jpp_pkg::CFG_D_GAIN:     cfg_nxt.d_gain     = cfg_data;
        jpp_pkg::CFG_I_LIMIT:    cfg_nxt.i_limit    = cfg_data[jpp_pkg::LIM_W-1:0];
        jpp_pkg::CFG_FINE_ANGLE: cfg_nxt.fine_angle = cfg_data[jpp_pkg::FINE_W-1:0];
        jpp_pkg::CFG_VEL_LIMIT:  cfg_nxt.vel_limit  = cfg_data[jpp_pkg::LIM_W-1:0];
        jpp_pkg::CFG_MIN_PWM:    cfg_nxt.min_pwm    = cfg_data[jpp_pkg::LIM_W-1:0];
        jpp_pkg::CFG_MAX_PWM:    cfg_nxt.max_pwm    = cfg_data[jpp_pkg::LIM_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain     <= jpp_pkg::P_GAIN_RST;
      cfg_r.i_gain     <= jpp_pkg::I_GAIN_RST;
      cfg_r.d_gain     <= jpp_pkg::D_GAIN_RST;
      cfg_r.i_limit    <= jpp_pkg::I_LIMIT_RST;
      cfg_r.fine_angle <= jpp_pkg::FINE_ANGLE_RST;
      cfg_r.vel_limit  <= jpp_pkg::VEL_LIMIT_RST;
      cfg_r.min_pwm    <= jpp_pkg::MIN_PWM_RST;
      cfg_r.max_pwm    <= jpp_pkg::MAX_PWM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/jpp_err_stage.sv =====
// Error stage: angle error, deadband and fine-band tests, the three gain
// products and the per-joint previous error store. Depends on jpp_pkg.
module jpp_err_stage #(
  parameter int JOINT_COUNT = jpp_pkg::JOINT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s0_valid,
  input  logic [jpp_pkg::JOINT_W-1:0]         s0_joint,
  input  logic signed [jpp_pkg::ANGLE_W-1:0]  s0_target,
  input  logic signed [jpp_pkg::ANGLE_W-1:0]  s0_measured,
  input  jpp_pkg::cfg_t                       cfg,
  input  logic                                s1_ready,
  output logic                                s0_ready,
  output logic                                s1_valid,
  output jpp_pkg::term_t                      s1_term
);

  localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  logic signed [jpp_pkg::ERR_W-1:0]   prev_err_r [JOINT_COUNT];
  logic                               s1_valid_r;
  logic                               s1_valid_nxt;
  jpp_pkg::term_t                     s1_term_r;
  jpp_pkg::term_t                     s1_term_nxt;

  logic                               s0_fire;
  logic [JIDX_W-1:0]                  jidx;
  logic                               joint_ok;
  logic signed [jpp_pkg::ERR_W-1:0]   err;
  logic [jpp_pkg::ERR_W-1:0]          err_mag;
  logic signed [jpp_pkg::ERR_W-1:0]   prev_err;
  logic signed [jpp_pkg::DIFF_W-1:0]  err_diff;

  assign s0_ready = !s1_valid_r || s1_ready;
  assign s0_fire  = s0_valid && s0_ready;

  assign jidx     = JIDX_W'(s0_joint);
  assign joint_ok = 32'(s0_joint) < JOINT_COUNT;
  assign err      = jpp_pkg::ERR_W'(s0_target) - jpp_pkg::ERR_W'(s0_measured);
  assign err_mag  = err[jpp_pkg::ERR_W-1] ? jpp_pkg::ERR_W'(-err) : jpp_pkg::ERR_W'(err);
  assign prev_err = prev_err_r[jidx];
  assign err_diff = jpp_pkg::DIFF_W'(err) - jpp_pkg::DIFF_W'(prev_err);

  always_comb begin
    s1_term_nxt.joint    = s0_joint;
    s1_term_nxt.joint_ok = joint_ok;
    s1_term_nxt.moving   = joint_ok &&
                           (err_mag > jpp_pkg::ERR_W'(jpp_pkg::DEADBAND_LSB));
    s1_term_nxt.fine     = err_mag < jpp_pkg::ERR_W'(cfg.fine_angle);
    s1_term_nxt.p        = jpp_pkg::PROD_W'(err) *
                           jpp_pkg::PROD_W'($signed({1'b0, cfg.p_gain}));
    s1_term_nxt.ei       = jpp_pkg::PROD_W'(err) *
                           jpp_pkg::PROD_W'($signed({1'b0, cfg.i_gain}));
    s1_term_nxt.d        = jpp_pkg::DPROD_W'(err_diff) *
                           jpp_pkg::DPROD_W'($signed({1'b0, cfg.d_gain}));
  end

  always_comb begin
    if (s0_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int k = 0; k < JOINT_COUNT; k++) begin
        prev_err_r[k] <= '0;
      end
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s0_fire && s1_term_nxt.moving) begin
        prev_err_r[jidx] <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      s1_term_r <= s1_term_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_term  = s1_term_r;

endmodule

// ===== hdl/jpp_out_stage.sv =====
// Output stage: integral update and clamp, velocity sum and clamp, PWM
// shaping, the per-joint integral store and the result register.
// Depends on jpp_pkg.
module jpp_out_stage #(
  parameter int JOINT_COUNT = jpp_pkg::JOINT_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               s1_valid,
  input  jpp_pkg::term_t                     s1_term,
  input  jpp_pkg::cfg_t                      cfg,
  input  logic                               out_stall,
  output logic                               s1_ready,
  output logic                               out_valid,
  output logic [jpp_pkg::JOINT_W-1:0]        out_joint_out,
  output logic signed [jpp_pkg::PWM_W-1:0]   out_pwm,
  output logic                               out_moving
);

  localparam int JIDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int SUM_W  = jpp_pkg::SUM_W;
  localparam int VEL_W  = jpp_pkg::VEL_W;
  localparam int LIM_W  = jpp_pkg::LIM_W;
  localparam int PWM_W  = jpp_pkg::PWM_W;
  localparam int FRAC   = jpp_pkg::FRAC_BITS;

  logic signed [jpp_pkg::ACC_W-1:0]  integral_r [JOINT_COUNT];
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [jpp_pkg::JOINT_W-1:0]       out_joint_r;
  logic signed [PWM_W-1:0]           out_pwm_r;
  logic signed [PWM_W-1:0]           out_pwm_nxt;
  logic                              out_moving_r;

  logic                              s1_fire;
  logic [JIDX_W-1:0]                 jidx;
  logic signed [SUM_W-1:0]           acc_sum;
  logic signed [SUM_W-1:0]           i_lim;
  logic signed [SUM_W-1:0]           acc_cl;
  logic signed [VEL_W-1:0]           pd_sum;
  logic signed [VEL_W-1:0]           vel_raw;
  logic signed [VEL_W-1:0]           v_lim;
  logic signed [VEL_W-1:0]           vel;
  logic                              vel_neg;
  logic [VEL_W-1:0]                  vel_mag;
  logic [LIM_W-1:0]                  mag_trunc;
  logic [LIM_W-1:0]                  mag_lo;
  logic [LIM_W-1:0]                  mag_hi;

  assign s1_ready = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid && s1_ready;
  assign jidx     = JIDX_W'(s1_term.joint);

  assign acc_sum = SUM_W'(integral_r[jidx]) + SUM_W'(s1_term.ei);
  assign i_lim   = $signed(SUM_W'({cfg.i_limit, {FRAC{1'b0}}}));
  assign acc_cl  = (acc_sum < -i_lim) ? -i_lim : ((acc_sum > i_lim) ? i_lim : acc_sum);

  assign pd_sum  = VEL_W'(s1_term.p) + VEL_W'(s1_term.d);
  assign vel_raw = s1_term.fine ? (VEL_W'(s1_term.p) <<< 1) : (pd_sum + VEL_W'(acc_cl));
  assign v_lim   = $signed(VEL_W'({cfg.vel_limit, {FRAC{1'b0}}}));
  assign vel     = (vel_raw < -v_lim) ? -v_lim : ((vel_raw > v_lim) ? v_lim : vel_raw);

  assign vel_neg   = vel[VEL_W-1];
  assign vel_mag   = vel_neg ? VEL_W'(-vel) : VEL_W'(vel);
  assign mag_trunc = vel_mag[FRAC +: LIM_W];
  assign mag_lo    = (mag_trunc < cfg.min_pwm) ? cfg.min_pwm : mag_trunc;
  assign mag_hi    = (mag_lo > cfg.max_pwm) ? cfg.max_pwm : mag_lo;

  always_comb begin
    if (!s1_term.moving) begin
      out_pwm_nxt = '0;
    end else if (vel_neg) begin
      out_pwm_nxt = -$signed(PWM_W'(mag_hi));
    end else begin
      out_pwm_nxt = $signed(PWM_W'(mag_hi));
    end
  end

  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < JOINT_COUNT; k++) begin
        integral_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire && s1_term.joint_ok) begin
        if (s1_term.moving) begin
          integral_r[jidx] <= jpp_pkg::ACC_W'(acc_cl);
        end else begin
          integral_r[jidx] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_joint_r  <= s1_term.joint;
      out_pwm_r    <= out_pwm_nxt;
      out_moving_r <= s1_term.moving;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_joint_out = out_joint_r;
  assign out_pwm       = out_pwm_r;
  assign out_moving    = out_moving_r;

  a_idle_pwm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_moving_r |-> out_pwm_r == '0)
    else $error("pwm is not zero on a result that is not moving");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(s1_valid))
    else $error("result appeared without a request in the output stage");

  a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pwm_r != $signed({1'b1, {(PWM_W-1){1'b0}}}))
    else $error("pwm magnitude exceeds its range");

endmodule

// ===== hdl/joint_position_pid.sv =====
// Joint position PID controller with velocity and PWM clamps.
// Each request carries a joint number, a desired and a measured angle in
// Q3.12 radians; each result carries the joint, a signed PWM and a moving flag.
// Channels: in_* and out_* use valid and stall; a request moves on a rising
// edge with valid high and stall low. The cfg_* port writes one gain or
// limit register per cycle with cfg_we; write only while the block is idle.
// The pipeline is an input register, an error and product stage, and an
// integral, velocity and PWM stage ending in the result register. Each stage
// registers a request in turn. One request is taken every cycle while
// in_stall is low; the per-joint integral and previous error are updated as
// a request leaves the stage that reads them, so back-to-back requests for
// the same joint see each other's state.
// When out_stall is high the result register holds; the stages behind it keep
// filling until all are full, and only then is in_stall raised.
// Reset clears the pipeline, loads the register defaults and zeroes the
// integral and previous error of every joint.
module joint_position_pid #(
  parameter int JOINT_COUNT = jpp_pkg::JOINT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [jpp_pkg::JOINT_W-1:0]         in_joint,
  input  logic signed [jpp_pkg::ANGLE_W-1:0]  in_target_angle,
  input  logic signed [jpp_pkg::ANGLE_W-1:0]  in_measured_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [jpp_pkg::JOINT_W-1:0]         out_joint_out,
  output logic signed [jpp_pkg::PWM_W-1:0]    out_pwm,
  output logic                                out_moving,
  input  logic                                cfg_we,
  input  logic [jpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  jpp_pkg::cfg_t                       cfg;
  jpp_pkg::term_t                      s1_term;
  logic                                s1_valid;
  logic                                s1_ready;
  logic                                s0_ready;

  logic                                s0_valid_r;
  logic                                s0_valid_nxt;
  logic [jpp_pkg::JOINT_W-1:0]         s0_joint_r;
  logic signed [jpp_pkg::ANGLE_W-1:0]  s0_target_r;
  logic signed [jpp_pkg::ANGLE_W-1:0]  s0_measured_r;
  logic                                in_fire;

  assign in_stall = s0_valid_r && !s0_ready;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    if (in_fire) begin
      s0_valid_nxt = 1'b1;
    end else if (s0_ready) begin
      s0_valid_nxt = 1'b0;
    end else begin
      s0_valid_nxt = s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_joint_r    <= in_joint;
      s0_target_r   <= in_target_angle;
      s0_measured_r <= in_measured_angle;
    end
  end

  jpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jpp_err_stage #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_err (
    .clk         (clk),
    .rst_n       (rst_n),
    .s0_valid    (s0_valid_r),
    .s0_joint    (s0_joint_r),
    .s0_target   (s0_target_r),
    .s0_measured (s0_measured_r),
    .cfg         (cfg),
    .s1_ready    (s1_ready),
    .s0_ready    (s0_ready),
    .s1_valid    (s1_valid),
    .s1_term     (s1_term)
  );

  jpp_out_stage #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .s1_term       (s1_term),
    .cfg           (cfg),
    .out_stall     (out_stall),
    .s1_ready      (s1_ready),
    .out_valid     (out_valid),
    .out_joint_out (out_joint_out),
    .out_pwm       (out_pwm),
    .out_moving    (out_moving)
  );

endmodule

// ===== verif/tb_joint_position_pid.sv =====
// Self-checking testbench for joint_position_pid: drives joint requests and
// configuration writes and checks each command against an in-bench PID predictor.
// Depends on hdl/jpp_pkg.sv and hdl/joint_position_pid.sv.
`timescale 1ns / 100ps

module tb_joint_position_pid;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES = 9;
  localparam int REQS_PER_PHASE = 155;
  localparam int ANGLE_MAX = 12868;
  localparam int ERR_SPAN = 2 * ANGLE_MAX;
  localparam logic [jpp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd13;

  typedef struct {
    logic [jpp_pkg::JOINT_W-1:0]       joint;
    logic signed [jpp_pkg::PWM_W-1:0]  pwm;
    logic                              moving;
  } pwm_cmd_t;

  class joint_cmd_scoreboard;
    jpp_pkg::cfg_t regs;
    int integral_acc[jpp_pkg::JOINT_COUNT_DEF];
    shortint last_error[jpp_pkg::JOINT_COUNT_DEF];
    pwm_cmd_t expected_cmds[$];
    int failures;

    function new();
      regs.p_gain = jpp_pkg::P_GAIN_RST;
      regs.i_gain = jpp_pkg::I_GAIN_RST;
      regs.d_gain = jpp_pkg::D_GAIN_RST;
      regs.i_limit = jpp_pkg::I_LIMIT_RST;
      regs.fine_angle = jpp_pkg::FINE_ANGLE_RST;
      regs.vel_limit = jpp_pkg::VEL_LIMIT_RST;
      regs.min_pwm = jpp_pkg::MIN_PWM_RST;
      regs.max_pwm = jpp_pkg::MAX_PWM_RST;
      foreach (integral_acc[k]) begin
        integral_acc[k] = 0;
        last_error[k] = 0;
      end
      failures = 0;
    endfunction

    function void write_reg(logic [jpp_pkg::CFG_IDX_W-1:0] idx,
                            logic [jpp_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        jpp_pkg::CFG_P_GAIN: begin
          regs.p_gain = value;
        end
        jpp_pkg::CFG_I_GAIN: begin
          regs.i_gain = value;
        end
        jpp_pkg::CFG_D_GAIN: begin
          regs.d_gain = value;
        end
        jpp_pkg::CFG_I_LIMIT: begin
          regs.i_limit = value[jpp_pkg::LIM_W-1:0];
        end
        jpp_pkg::CFG_FINE_ANGLE: begin
          regs.fine_angle = value[jpp_pkg::FINE_W-1:0];
        end
        jpp_pkg::CFG_VEL_LIMIT: begin
          regs.vel_limit = value[jpp_pkg::LIM_W-1:0];
        end
        jpp_pkg::CFG_MIN_PWM: begin
          regs.min_pwm = value[jpp_pkg::LIM_W-1:0];
        end
        jpp_pkg::CFG_MAX_PWM: begin
          regs.max_pwm = value[jpp_pkg::LIM_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v < -lim) return -lim;
      if (v > lim) return lim;
      return v;
    endfunction

    function void note_request(logic [jpp_pkg::JOINT_W-1:0] j,
                               logic signed [jpp_pkg::ANGLE_W-1:0] tgt,
                               logic signed [jpp_pkg::ANGLE_W-1:0] meas);
      longint err, mag, p, acc, d, vel, vmag, ilim, vlim, cmd;
      pwm_cmd_t c;
      err = longint'(tgt) - longint'(meas);
      mag = (err < 0) ? -err : err;
      c.joint = j;
      c.pwm = '0;
      c.moving = 1'b0;
      if (mag > jpp_pkg::DEADBAND_LSB) begin
        p = err * longint'(regs.p_gain);
        ilim = longint'(regs.i_limit) <<< jpp_pkg::FRAC_BITS;
        vlim = longint'(regs.vel_limit) <<< jpp_pkg::FRAC_BITS;
        acc = clamp_sym(longint'(integral_acc[j]) + err * longint'(regs.i_gain), ilim);
        integral_acc[j] = int'(acc);
        d = (err - longint'(last_error[j])) * longint'(regs.d_gain);
        vel = (mag < longint'(regs.fine_angle)) ? 2 * p : p + acc + d;
        vel = clamp_sym(vel, vlim);
        vmag = (vel < 0) ? -vel : vel;
        cmd = vmag >>> jpp_pkg::FRAC_BITS;
        if (cmd < longint'(regs.min_pwm)) cmd = longint'(regs.min_pwm);
        if (cmd > longint'(regs.max_pwm)) cmd = longint'(regs.max_pwm);
        if (vel < 0) cmd = -cmd;
        c.pwm = cmd[jpp_pkg::PWM_W-1:0];
        c.moving = 1'b1;
        last_error[j] = shortint'(err);
      end else begin
        integral_acc[j] = 0;
      end
      expected_cmds.push_back(c);
    endfunction

    function void check_command(logic [jpp_pkg::JOINT_W-1:0] j,
                                logic signed [jpp_pkg::PWM_W-1:0] pwm, logic moving);
      pwm_cmd_t c;
      if (expected_cmds.size() == 0) begin
        $error("command for joint %0d arrived with nothing outstanding", j);
        failures++;
        return;
      end
      c = expected_cmds.pop_front();
      if (j !== c.joint) begin
        $error("joint_out: expected %0d, actual %0d", c.joint, j);
        failures++;
      end
      if (pwm !== c.pwm) begin
        $error("pwm: expected %0d, actual %0d", c.pwm, pwm);
        failures++;
      end
      if (moving !== c.moving) begin
        $error("moving: expected %0d, actual %0d", c.moving, moving);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_cmds.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [jpp_pkg::JOINT_W-1:0] in_joint;
  logic signed [jpp_pkg::ANGLE_W-1:0] in_target_angle;
  logic signed [jpp_pkg::ANGLE_W-1:0] in_measured_angle;
  logic out_valid;
  logic out_stall;
  logic [jpp_pkg::JOINT_W-1:0] out_joint_out;
  logic signed [jpp_pkg::PWM_W-1:0] out_pwm;
  logic out_moving;
  logic cfg_we;
  logic [jpp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [jpp_pkg::CFG_DATA_W-1:0] cfg_data;

  joint_cmd_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int cycle_count = 0;

  joint_position_pid i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_joint         (in_joint),
    .in_target_angle  (in_target_angle),
    .in_measured_angle(in_measured_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_joint_out    (out_joint_out),
    .out_pwm          (out_pwm),
    .out_moving       (out_moving),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("joint_position_pid verification failed");
      $finish;
    end
  end

  // The receiver stalls at random, or for a fixed stretch when a hold-off is asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len = hold_len - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_command(out_joint_out, out_pwm, out_moving);
    end
  end

  task automatic send_request(logic [jpp_pkg::JOINT_W-1:0] j,
                              logic signed [jpp_pkg::ANGLE_W-1:0] tgt,
                              logic signed [jpp_pkg::ANGLE_W-1:0] meas);
    in_valid <= 1'b1;
    in_joint <= j;
    in_target_angle <= tgt;
    in_measured_angle <= meas;
    do @(posedge clk); while (in_stall);
    sb.note_request(j, tgt, meas);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic program_reg(logic [jpp_pkg::CFG_IDX_W-1:0] idx,
                             logic [jpp_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic program_all(int pg, int ig, int dg, int il, int fa, int vl, int mn, int mx);
    program_reg(jpp_pkg::CFG_P_GAIN, jpp_pkg::CFG_DATA_W'(pg));
    program_reg(jpp_pkg::CFG_I_GAIN, jpp_pkg::CFG_DATA_W'(ig));
    program_reg(jpp_pkg::CFG_D_GAIN, jpp_pkg::CFG_DATA_W'(dg));
    program_reg(jpp_pkg::CFG_I_LIMIT, jpp_pkg::CFG_DATA_W'(il));
    program_reg(jpp_pkg::CFG_FINE_ANGLE, jpp_pkg::CFG_DATA_W'(fa));
    program_reg(jpp_pkg::CFG_VEL_LIMIT, jpp_pkg::CFG_DATA_W'(vl));
    program_reg(jpp_pkg::CFG_MIN_PWM, jpp_pkg::CFG_DATA_W'(mn));
    program_reg(jpp_pkg::CFG_MAX_PWM, jpp_pkg::CFG_DATA_W'(mx));
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_gain();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 1023);
      1: return $urandom_range(0, 8191);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic configure_phase(int ph);
    int mn, mx;
    case (ph)
      0: begin
      end
      1: program_all(65535, 65535, 65535, 255, 16383, 255, 0, 255);
      2: program_all(0, 0, 0, 0, 0, 0, 0, 0);
      3: program_all(0, 0, 0, 255, 0, 255, 77, 200);
      4: program_all(rand_gain(), rand_gain(), rand_gain(), $urandom_range(0, 255),
                     $urandom_range(0, ANGLE_MAX), $urandom_range(0, 255), 200, 50);
      default: begin
        mn = $urandom_range(0, 60);
        mx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(100, 255);
        if (ph == 5) begin
          program_reg(CFG_IDX_SPARE, jpp_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
        end
        program_all(rand_gain(), rand_gain(), rand_gain(), $urandom_range(0, 255),
                    $urandom_range(0, ANGLE_MAX), $urandom_range(0, 255), mn, mx);
      end
    endcase
    case (ph % 4)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 87;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 87;
      end
      default: begin
        send_idle_pct = 7;
        stall_pct = 7;
      end
    endcase
  endtask

  // Some requests carry an error near one of the decision points: the deadband
  // edge or the fine-angle threshold. A few use the full 15-bit input range.
  task automatic random_request();
    int err, mag, lo, hi, meas, pick;
    logic signed [jpp_pkg::ANGLE_W-1:0] tgt_bits, meas_bits;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      tgt_bits = jpp_pkg::ANGLE_W'($urandom_range(0, 32767));
      meas_bits = jpp_pkg::ANGLE_W'($urandom_range(0, 32767));
    end else begin
      if (pick < 15) begin
        mag = $urandom_range(0, 23);
      end else if (pick < 40) begin
        mag = int'(sb.regs.fine_angle) + $urandom_range(0, 40) - 20;
        if (mag < 21) mag = 21 + $urandom_range(0, 30);
        if (mag > ERR_SPAN) mag = ERR_SPAN - $urandom_range(0, 20);
      end else if (pick < 70) begin
        mag = $urandom_range(0, 2048);
      end else begin
        mag = $urandom_range(0, ERR_SPAN);
      end
      err = ($urandom_range(0, 99) < 65) ? mag : -mag;
      lo = (err > 0) ? -ANGLE_MAX : -ANGLE_MAX - err;
      hi = (err > 0) ? ANGLE_MAX - err : ANGLE_MAX;
      meas = lo + $urandom_range(0, hi - lo);
      tgt_bits = jpp_pkg::ANGLE_W'(meas + err);
      meas_bits = jpp_pkg::ANGLE_W'(meas);
    end
    send_request(jpp_pkg::JOINT_W'($urandom_range(0, jpp_pkg::JOINT_COUNT_DEF - 1)),
                 tgt_bits, meas_bits);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_joint <= '0;
    in_target_angle <= '0;
    in_measured_angle <= '0;
    cfg_we <= 1'b0;
    cfg_index <= jpp_pkg::CFG_P_GAIN;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: deadband edges, the fine-angle edge and the input extremes.
    send_request(0, 0, 0);
    send_request(1, 20, 0);
    send_request(1, -21, 0);
    send_request(2, 12868, -12868);
    send_request(3, -12868, 12868);
    send_request(0, -16384, 16383);
    send_request(0, 16383, -16384);
    send_request(1, 409, 0);
    send_request(1, 410, 0);
    wait_drained();
    program_all(4096, 2048, 1024, 40, 410, 200, 30, 180);
    // Integral wind-up that stays below its clamp, then a deadband visit that clears it,
    // then a sign reversal that exercises the derivative term.
    repeat (6) send_request(2, 2000, 0);
    send_request(2, 5, 0);
    send_request(2, -2000, 0);
    send_request(2, 0, 2000);
    send_request(3, 300, 0);
    send_request(3, -500, 0);
    send_request(1, 12868, 12847);
    send_request(1, -12868, -12847);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      configure_phase(ph);
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        if (ph % 4 == 0 && n == 40) hold_len = 150;
        if (n == 100) wait_drained();
        random_request();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("joint_position_pid verification clean");
    end else begin
      $display("joint_position_pid verification failed");
    end
    $finish;
  end

endmodule
